// ===== hdl/vbsq_pkg.sv =====
// types and constants shared by the scalar quantize and pack block
package vbsq_pkg;

  localparam int FRAC_BITS = 12;

  localparam logic [1:0] PREC_2BIT   = 2'd0;
  localparam logic [1:0] PREC_4BIT   = 2'd1;
  localparam logic [1:0] PREC_8BIT   = 2'd2;
  localparam logic [1:0] PREC_UNUSED = 2'd3;

  localparam logic [3:0] WIDTH_2BIT = 4'd2;
  localparam logic [3:0] WIDTH_4BIT = 4'd4;
  localparam logic [3:0] WIDTH_8BIT = 4'd8;

  localparam int OFS_LOW    = 3 << FRAC_BITS;
  localparam int OFS_HIGH   = 4 << FRAC_BITS;
  localparam int Q4_SHIFT   = FRAC_BITS - 3;
  localparam int Q4_STEP    = 3 << Q4_SHIFT;
  localparam int Q4_SAT     = 15 * Q4_STEP;
  localparam int DIV3_MUL   = 43;
  localparam int DIV3_SHIFT = 7;
  localparam int Q8_SHIFT   = FRAC_BITS + 3;
  localparam int Q8_SAT     = ((256 << Q8_SHIFT) + 254) / 255;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] code;
    logic [3:0] width;
    logic       last;
  } qentry_t;

endpackage

// ===== hdl/vbsq_if.sv =====
// channel interfaces for samples in and packed code bytes out
interface vbsq_sample_if #(parameter int SAMPLE_BITS = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [1:0]                    precision;
  logic                          last_element;

  modport source(output valid, sample, precision, last_element, input ready);
  modport sink(input valid, sample, precision, last_element, output ready);
endinterface

interface vbsq_byte_if ();
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_byte;

  modport source(output valid, code_byte, last_byte, input ready);
  modport sink(input valid, code_byte, last_byte, output ready);
endinterface

// ===== hdl/vbsq_front.sv =====
// front end: quantizes one sample to a 2, 4 or 8 bit code
module vbsq_front import vbsq_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [1:0]                    precision,
  input  logic                          last_element,
  output qentry_t                       entry
);

  localparam int NUM_W = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;

  logic signed [NUM_W-1:0] s_ext;
  logic signed [NUM_W-1:0] num_lo;
  logic signed [NUM_W-1:0] num_hi;
  logic [5:0]              n9;
  logic [11:0]             n9_prod;
  logic [3:0]              q4;
  logic [15:0]             num_hi_u;
  logic [23:0]             prod;
  logic [7:0]              q8;

  assign s_ext  = {{(NUM_W-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
  assign num_lo = s_ext + $signed(NUM_W'(OFS_LOW));
  assign num_hi = s_ext + $signed(NUM_W'(OFS_HIGH));

  // divide by three through a reciprocal, valid for the unsaturated range
  assign n9      = num_lo[Q4_SHIFT+5:Q4_SHIFT];
  assign n9_prod = 12'(n9) * 12'(DIV3_MUL);

  always_comb begin
    if (num_lo[NUM_W-1]) begin
      q4 = 4'd0;
    end else if (num_lo >= $signed(NUM_W'(Q4_SAT))) begin
      q4 = 4'd15;
    end else begin
      q4 = 4'(n9_prod >> DIV3_SHIFT);
    end
  end

  assign num_hi_u = num_hi[15:0];
  assign prod     = 24'(num_hi_u) * 24'(255);

  always_comb begin
    if (num_hi[NUM_W-1]) begin
      q8 = 8'd0;
    end else if (num_hi >= $signed(NUM_W'(Q8_SAT))) begin
      q8 = 8'd255;
    end else begin
      q8 = prod[Q8_SHIFT+7:Q8_SHIFT];
    end
  end

  always_comb begin
    entry.last = last_element;
    case (precision)
      PREC_2BIT: begin
        entry.code  = {6'd0, q4[3:2]};
        entry.width = WIDTH_2BIT;
      end
      PREC_4BIT: begin
        entry.code  = {4'd0, q4};
        entry.width = WIDTH_4BIT;
      end
      default: begin
        entry.code  = q8;
        entry.width = WIDTH_8BIT;
      end
    endcase
  end

endmodule

// ===== hdl/vbsq_queue.sv =====
// short queue of quantized codes between front and back
module vbsq_queue import vbsq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  qentry_t push_entry,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output qentry_t head
);

  qentry_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/vbsq_back.sv =====
// back end: packs codes lsb first into bytes and holds the output register
module vbsq_back import vbsq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  qentry_t    head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [7:0]  acc;
  logic [2:0]  fill;
  logic [14:0] shifted;
  logic [7:0]  merged;
  logic [3:0]  total;
  logic        emit;

  assign pop     = head_valid && (!out_valid || out_ready);
  assign shifted = 15'(head.code) << fill;
  assign merged  = acc | shifted[7:0];
  assign total   = 4'(fill) + head.width;
  assign emit    = total[3] || head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      acc       <= '0;
      fill      <= '0;
    end else begin
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (emit) begin
          acc  <= '0;
          fill <= '0;
        end else begin
          acc  <= merged;
          fill <= total[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_byte <= merged;
      out_last <= head.last;
    end
  end

endmodule

// ===== hdl/variable_bit_scalar_quantize_pack.sv =====
// top level of the variable width scalar quantizer and bit packer
//
//  channel   dir  payload                              handshake
//  samples   in   sample, precision, last_element      valid / ready
//  codes     out  code_byte, last_byte                 valid / ready
//
// one item per cycle while the output is not stalled; the item that completes a code byte
// passes through the two-entry queue and then into the output register
// rst is synchronous and clears the queue, the accumulator and the output
// a stalled output fills the queue, after which samples.ready drops
module variable_bit_scalar_quantize_pack import vbsq_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  vbsq_sample_if.sink samples,
  vbsq_byte_if.source codes
);

  qentry_t front_entry;
  qentry_t head;
  logic    full;
  logic    head_valid;
  logic    pop;

  vbsq_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .sample       (samples.sample),
    .precision    (samples.precision),
    .last_element (samples.last_element),
    .entry        (front_entry)
  );

  assign samples.ready = !full;

  vbsq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (samples.valid),
    .push_entry (front_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  vbsq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (codes.valid),
    .out_ready  (codes.ready),
    .out_byte   (codes.code_byte),
    .out_last   (codes.last_byte)
  );

endmodule

// ===== hdl/vbsq_checker.sv =====
// port level checks for the quantize and pack block, bound to the top level
module vbsq_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // output register is empty right after reset
  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  // the queue can only fill while the output is stalled
  a_full_needs_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output register");

  // a stalled byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output item changed");

endmodule

bind variable_bit_scalar_quantize_pack vbsq_checker u_vbsq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (samples.ready),
  .out_valid (codes.valid),
  .out_ready (codes.ready),
  .out_byte  (codes.code_byte),
  .out_last  (codes.last_byte)
);
